// File: hw/rtl/lfv_pkg.sv
// Shared types and constants for the log frustum volume block.
// No dependencies; the other files that use it refer to it by scoped names.
package lfv_pkg;

  localparam int FRAC_BITS = 8;
  localparam int ROOT_BITS = 32;

  // Area factors, unsigned Q0.32
  localparam logic [63:0] PI4_Q32_W = 64'd3373259426;
  localparam logic [31:0] PI4_Q32   = 32'(PI4_Q32_W);
  localparam logic [31:0] IMP_Q32   = 32'((PI4_Q32_W + 64'd72) / 64'd144);
  localparam logic [31:0] MET_Q32   = 32'((PI4_Q32_W + 64'd5000) / 64'd10000);

  // floor((2^32 - 1) / 3), used for divide-by-three estimate
  localparam logic [31:0] THIRD_Q32 = 32'h5555_5555;

  localparam logic [39:0] VOL_MAX = 40'hFF_FFFF_FFFF;

  // Register indexes
  localparam logic REG_UNIT_SYSTEM = 1'b0;
  localparam logic REG_SAME_UNITS  = 1'b1;

  // Unit systems
  localparam logic [1:0] UNIT_IMPERIAL = 2'd0;
  localparam logic [1:0] UNIT_METRIC   = 2'd1;

  // Volume rules
  localparam logic [1:0] CMD_SMALIAN = 2'd0;
  localparam logic [1:0] CMD_CONE    = 2'd1;
  localparam logic [1:0] CMD_NEILOID = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_UNITS = 2'd1;
  localparam logic [1:0] ST_BAD_RULE  = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // Per-item data that travels alongside the root stages
  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  st;
    logic [15:0] len;
    logic [31:0] as;
    logic [31:0] al;
  } side_t;

endpackage

// File: hw/rtl/lfv_if.sv
// Valid/ready channel interfaces for the log frustum volume block.
// No dependencies.
interface lfv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] small_diameter;
  logic [15:0] large_diameter;
  logic [15:0] log_length;

  modport source (output valid, cmd, small_diameter, large_diameter, log_length,
                  input ready);
  modport sink   (input valid, cmd, small_diameter, large_diameter, log_length,
                  output ready);
endinterface

interface lfv_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] volume;
  logic [1:0]  status;

  modport source (output valid, volume, status, input ready);
  modport sink   (input valid, volume, status, output ready);
endinterface

// File: hw/rtl/lfv_root_pipe.sv
// Pipelined integer roots: one square root and two cube roots, one result bit
// per stage. Depends on lfv_pkg.
module lfv_root_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  lfv_pkg::side_t    in_side,
  input  logic [63:0]       sq_n,
  input  logic [95:0]       cb_a_n,
  input  logic [95:0]       cb_b_n,
  output logic              out_valid,
  output lfv_pkg::side_t    out_side,
  output logic [31:0]       sq_root,
  output logic [31:0]       cb_a_root,
  output logic [31:0]       cb_b_root
);

  localparam int Steps = lfv_pkg::ROOT_BITS;

  logic           v_r     [1:Steps];
  lfv_pkg::side_t side_r  [1:Steps];
  logic [63:0]    sn_r    [1:Steps];
  logic [31:0]    sr_r    [1:Steps];
  logic [63:0]    sr2_r   [1:Steps];
  logic [95:0]    an_r    [1:Steps];
  logic [31:0]    ar_r    [1:Steps];
  logic [63:0]    ar2_r   [1:Steps];
  logic [95:0]    ar3_r   [1:Steps];
  logic [95:0]    bn_r    [1:Steps];
  logic [31:0]    br_r    [1:Steps];
  logic [63:0]    br2_r   [1:Steps];
  logic [95:0]    br3_r   [1:Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int B = Steps - 1 - s;

    logic           cv;
    lfv_pkg::side_t cside;
    logic [63:0]    csn, csr2, car2, cbr2;
    logic [31:0]    csr, car, cbr;
    logic [95:0]    can, car3, cbn, cbr3;
    logic [63:0]    st2, at2, bt2;
    logic [95:0]    at3, bt3;
    logic [31:0]    bitm;

    if (s == 0) begin : g_first
      assign cv = in_valid;
      assign cside = in_side;
      assign csn = sq_n;
      assign csr = '0;
      assign csr2 = '0;
      assign can = cb_a_n;
      assign car = '0;
      assign car2 = '0;
      assign car3 = '0;
      assign cbn = cb_b_n;
      assign cbr = '0;
      assign cbr2 = '0;
      assign cbr3 = '0;
    end else begin : g_mid
      assign cv = v_r[s];
      assign cside = side_r[s];
      assign csn = sn_r[s];
      assign csr = sr_r[s];
      assign csr2 = sr2_r[s];
      assign can = an_r[s];
      assign car = ar_r[s];
      assign car2 = ar2_r[s];
      assign car3 = ar3_r[s];
      assign cbn = bn_r[s];
      assign cbr = br_r[s];
      assign cbr2 = br2_r[s];
      assign cbr3 = br3_r[s];
    end

    assign bitm = 32'd1 << B;

    // (r + 2^B)^2 and (r + 2^B)^3 expanded, shifts and adds only
    assign st2 = csr2 + ({32'd0, csr} << (B + 1)) + (64'd1 << (2 * B));
    assign at2 = car2 + ({32'd0, car} << (B + 1)) + (64'd1 << (2 * B));
    assign bt2 = cbr2 + ({32'd0, cbr} << (B + 1)) + (64'd1 << (2 * B));
    assign at3 = car3 + (({32'd0, car2} + ({32'd0, car2} << 1)) << B)
               + (({64'd0, car} + ({64'd0, car} << 1)) << (2 * B))
               + (96'd1 << (3 * B));
    assign bt3 = cbr3 + (({32'd0, cbr2} + ({32'd0, cbr2} << 1)) << B)
               + (({64'd0, cbr} + ({64'd0, cbr} << 1)) << (2 * B))
               + (96'd1 << (3 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s+1] <= cside;
        sn_r[s+1]   <= csn;
        an_r[s+1]   <= can;
        bn_r[s+1]   <= cbn;
        if (st2 <= csn) begin
          sr_r[s+1]  <= csr | bitm;
          sr2_r[s+1] <= st2;
        end else begin
          sr_r[s+1]  <= csr;
          sr2_r[s+1] <= csr2;
        end
        if (at3 <= can) begin
          ar_r[s+1]  <= car | bitm;
          ar2_r[s+1] <= at2;
          ar3_r[s+1] <= at3;
        end else begin
          ar_r[s+1]  <= car;
          ar2_r[s+1] <= car2;
          ar3_r[s+1] <= car3;
        end
        if (bt3 <= cbn) begin
          br_r[s+1]  <= cbr | bitm;
          br2_r[s+1] <= bt2;
          br3_r[s+1] <= bt3;
        end else begin
          br_r[s+1]  <= cbr;
          br2_r[s+1] <= cbr2;
          br3_r[s+1] <= cbr3;
        end
      end
    end
  end

  assign out_valid = v_r[Steps];
  assign out_side  = side_r[Steps];
  assign sq_root   = sr_r[Steps];
  assign cb_a_root = ar_r[Steps];
  assign cb_b_root = br_r[Steps];

endmodule

// File: hw/rtl/log_frustum_volume_top.sv
// Log volume by Smalian, cone or neiloid rule, fully pipelined.
// Depends on lfv_pkg, lfv_if and lfv_root_pipe.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | cmd, small_diameter, large_diameter, log_length
//  out_ch  | out | valid/ready      | volume, status
//  cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the path from input transfer to output
// valid runs through 6 area/product stages, 32 root stages one bit each and 5 final stages.
// Reset clears the stage valid bits and the config registers.
// The pipeline moves as one: it holds while a result sits unaccepted at the
// output register, so in_ch.ready follows out_ch.ready or an empty output.
module log_frustum_volume_top (
  input  logic       clk,
  input  logic       rst_n,
  lfv_in_if.sink     in_ch,
  lfv_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data
);

  localparam int F = lfv_pkg::FRAC_BITS;

  logic [1:0] unit_r;
  logic       same_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= lfv_pkg::UNIT_IMPERIAL;
      same_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == lfv_pkg::REG_UNIT_SYSTEM) begin
        unit_r <= cfg_data;
      end else begin
        same_r <= cfg_data[0];
      end
    end
  end

  logic out_v_r;
  logic en;
  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 0: capture, pick factor and early status
  logic        v0_r;
  logic [1:0]  cmd0_r, st0_r;
  logic [15:0] ds0_r, dl0_r, len0_r;
  logic [31:0] k0_r;
  logic [31:0] k_nxt;
  logic [1:0]  st_nxt;

  always_comb begin
    if (same_r) begin
      k_nxt = lfv_pkg::PI4_Q32;
    end else if (unit_r == lfv_pkg::UNIT_IMPERIAL) begin
      k_nxt = lfv_pkg::IMP_Q32;
    end else begin
      k_nxt = lfv_pkg::MET_Q32;
    end
    if (unit_r != lfv_pkg::UNIT_IMPERIAL && unit_r != lfv_pkg::UNIT_METRIC) begin
      st_nxt = lfv_pkg::ST_BAD_UNITS;
    end else if (in_ch.cmd == lfv_pkg::CMD_UNKNOWN) begin
      st_nxt = lfv_pkg::ST_BAD_RULE;
    end else begin
      st_nxt = lfv_pkg::ST_OK;
    end
  end

  // Stage 1: diameter squares
  logic        v1_r;
  logic [1:0]  cmd1_r, st1_r;
  logic [15:0] len1_r;
  logic [31:0] k1_r, d2s1_r, d2l1_r;

  // Stage 2: areas, Q.2F
  logic           v2_r;
  lfv_pkg::side_t side2_r;
  logic [63:0]    ars_full, arl_full;

  assign ars_full = {32'd0, d2s1_r} * {32'd0, k1_r} + (64'd1 << 31);
  assign arl_full = {32'd0, d2l1_r} * {32'd0, k1_r} + (64'd1 << 31);

  // Stage 3: area products
  logic           v3_r;
  lfv_pkg::side_t side3_r;
  logic [63:0]    psq3_r, pss3_r, pll3_r;

  // Stage 4: partial products of the cube operands
  logic           v4_r;
  lfv_pkg::side_t side4_r;
  logic [63:0]    psq4_r, pa_lo4_r, pa_hi4_r, pb_lo4_r, pb_hi4_r;

  // Stage 5: full 96-bit cube operands
  logic           v5_r;
  lfv_pkg::side_t side5_r;
  logic [63:0]    psq5_r;
  logic [95:0]    na5_r, nb5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r <= in_ch.cmd;
      st0_r  <= st_nxt;
      ds0_r  <= in_ch.small_diameter;
      dl0_r  <= in_ch.large_diameter;
      len0_r <= in_ch.log_length;
      k0_r   <= k_nxt;

      cmd1_r <= cmd0_r;
      st1_r  <= st0_r;
      len1_r <= len0_r;
      k1_r   <= k0_r;
      d2s1_r <= {16'd0, ds0_r} * {16'd0, ds0_r};
      d2l1_r <= {16'd0, dl0_r} * {16'd0, dl0_r};

      side2_r.cmd <= cmd1_r;
      side2_r.st  <= st1_r;
      side2_r.len <= len1_r;
      side2_r.as  <= ars_full[63:32];
      side2_r.al  <= arl_full[63:32];

      side3_r <= side2_r;
      psq3_r  <= {32'd0, side2_r.as} * {32'd0, side2_r.al};
      pss3_r  <= {32'd0, side2_r.as} * {32'd0, side2_r.as};
      pll3_r  <= {32'd0, side2_r.al} * {32'd0, side2_r.al};

      side4_r  <= side3_r;
      psq4_r   <= psq3_r;
      pa_lo4_r <= {32'd0, pss3_r[31:0]}  * {32'd0, side3_r.al};
      pa_hi4_r <= {32'd0, pss3_r[63:32]} * {32'd0, side3_r.al};
      pb_lo4_r <= {32'd0, pll3_r[31:0]}  * {32'd0, side3_r.as};
      pb_hi4_r <= {32'd0, pll3_r[63:32]} * {32'd0, side3_r.as};

      side5_r <= side4_r;
      psq5_r  <= psq4_r;
      na5_r   <= {32'd0, pa_lo4_r} + ({32'd0, pa_hi4_r} << 32);
      nb5_r   <= {32'd0, pb_lo4_r} + ({32'd0, pb_hi4_r} << 32);
    end
  end

  logic           vr;
  lfv_pkg::side_t sider;
  logic [31:0]    rsq, rca, rcb;

  lfv_root_pipe u_roots (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_side   (side5_r),
    .sq_n      (psq5_r),
    .cb_a_n    (na5_r),
    .cb_b_n    (nb5_r),
    .out_valid (vr),
    .out_side  (sider),
    .sq_root   (rsq),
    .cb_a_root (rca),
    .cb_b_root (rcb)
  );

  // Final stages: sum, length product, rounding shift, divide by three
  logic        v6_r, v7_r, v8_r, v9_r;
  logic [1:0]  cmd6_r, st6_r, st7_r, st8_r, st9_r;
  logic        div3_8_r, div3_9_r;
  logic [15:0] len6_r;
  logic [34:0] sum6_r, sum_nxt;
  logic [1:0]  cmd7_r;
  logic [50:0] prod7_r;
  logic [34:0] y8_r, y_nxt;
  logic [34:0] qe9_r;
  logic [3:0]  ylo9_r;
  logic [66:0] qmul;

  always_comb begin
    case (sider.cmd)
      lfv_pkg::CMD_SMALIAN: sum_nxt = {3'd0, sider.as} + {3'd0, sider.al};
      lfv_pkg::CMD_CONE:    sum_nxt = {3'd0, sider.as} + {3'd0, sider.al}
                                    + {3'd0, rsq};
      lfv_pkg::CMD_NEILOID: sum_nxt = {3'd0, sider.as} + {3'd0, sider.al}
                                    + {3'd0, rca} + {3'd0, rcb};
      default:              sum_nxt = '0;
    endcase
  end

  always_comb begin
    case (cmd7_r)
      lfv_pkg::CMD_CONE: y_nxt = 35'((prod7_r + (51'd3 << (2 * F - 1))) >> (2 * F));
      lfv_pkg::CMD_NEILOID: y_nxt = 35'((prod7_r + (51'd1 << (2 * F + 1))) >> (2 * F + 2));
      default:           y_nxt = 35'((prod7_r + (51'd1 << (2 * F))) >> (2 * F + 1));
    endcase
  end

  assign qmul = {32'd0, y8_r} * {35'd0, lfv_pkg::THIRD_Q32};

  // Divide-by-three fixup: remainder of the estimate is below 12
  logic [36:0] three_q;
  logic [3:0]  rem;
  logic [34:0] q_fix;
  logic [40:0] q_ext;
  logic [39:0] vol_nxt;
  logic [1:0]  stat_nxt;

  always_comb begin
    three_q = {2'd0, qe9_r} + ({2'd0, qe9_r} << 1);
    rem     = ylo9_r - three_q[3:0];
    q_fix   = qe9_r;
    if (div3_9_r) begin
      q_fix = qe9_r + 35'(rem >= 4'd3) + 35'(rem >= 4'd6) + 35'(rem >= 4'd9);
    end
    q_ext = 41'(q_fix);
    if (st9_r != lfv_pkg::ST_OK) begin
      vol_nxt  = '0;
      stat_nxt = st9_r;
    end else if (q_ext > {1'b0, lfv_pkg::VOL_MAX}) begin
      vol_nxt  = lfv_pkg::VOL_MAX;
      stat_nxt = lfv_pkg::ST_SATURATED;
    end else begin
      vol_nxt  = q_ext[39:0];
      stat_nxt = lfv_pkg::ST_OK;
    end
  end

  logic [39:0] vol_r;
  logic [1:0]  stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      v8_r    <= 1'b0;
      v9_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v6_r    <= vr;
      v7_r    <= v6_r;
      v8_r    <= v7_r;
      v9_r    <= v8_r;
      out_v_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd6_r <= sider.cmd;
      st6_r  <= sider.st;
      len6_r <= sider.len;
      sum6_r <= sum_nxt;

      cmd7_r  <= cmd6_r;
      st7_r   <= st6_r;
      prod7_r <= {35'd0, len6_r} * {16'd0, sum6_r};

      st8_r    <= st7_r;
      div3_8_r <= (cmd7_r == lfv_pkg::CMD_CONE);
      y8_r     <= y_nxt;

      st9_r    <= st8_r;
      div3_9_r <= div3_8_r;
      ylo9_r   <= y8_r[3:0];
      qe9_r    <= div3_8_r ? qmul[66:32] : y8_r;

      vol_r  <= vol_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.volume = vol_r;
  assign out_ch.status = stat_r;

endmodule

// File: hw/rtl/lfv_check.sv
// Port-level checks for log_frustum_volume_top, attached by bind.
// Depends on lfv_pkg and the top level's ports.
module lfv_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_volume,
  input logic [1:0]  out_status
);

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lfv_pkg::ST_BAD_UNITS ||
                  out_status == lfv_pkg::ST_BAD_RULE) |-> out_volume == '0)
    else $error("error status with nonzero volume");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == lfv_pkg::ST_SATURATED |-> out_volume == lfv_pkg::VOL_MAX)
    else $error("saturated status without maximum volume");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_volume))
    else $error("stalled result changed");

endmodule

bind log_frustum_volume_top lfv_check u_lfv_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_volume (out_ch.volume),
  .out_status (out_ch.status)
);

// File: tb/sv/tb_top.sv
// Testbench for log_frustum_volume_top: random and directed logs against a bit-exact predictor.
// Depends on lfv_pkg, lfv_if and the RTL of log_frustum_volume_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] ds;
    logic [15:0] dl;
    logic [15:0] len;
  } log_item_t;

  typedef struct {
    logic [39:0] volume;
    logic [1:0]  status;
  } vol_res_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [1:0] cfg_data;

  lfv_in_if  in_ch();
  lfv_out_if out_ch();

  log_frustum_volume_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  log_item_t logs_pending[$];
  vol_res_t  volumes_expected[$];
  logic [1:0] unit_sel;
  logic       same_sel;
  bit         quiet;
  int         errors;
  int         stall_cnt;

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] area_of(logic [15:0] d, logic [31:0] k);
    logic [127:0] p;
    p = 128'(d) * 128'(d) * 128'(k) + (128'd1 << 31);
    return 32'(p >> 32);
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // floor cube root of a*a*b, the product reaches 96 bits
  function automatic logic [63:0] cbrt_floor(logic [31:0] a, logic [31:0] b);
    logic [127:0] n;
    logic [127:0] t;
    logic [127:0] r;
    n = 128'(a) * 128'(a) * 128'(b);
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t * t <= n) r = t;
    end
    return 64'(r);
  endfunction

  function automatic vol_res_t log_volume(log_item_t it);
    vol_res_t     res;
    logic [31:0]  k;
    logic [63:0]  as;
    logic [63:0]  al;
    logic [63:0]  sum;
    logic [63:0]  div;
    logic [127:0] v;
    res.volume = '0;
    if (unit_sel > lfv_pkg::UNIT_METRIC) begin
      res.status = lfv_pkg::ST_BAD_UNITS;
      return res;
    end
    if (it.cmd == lfv_pkg::CMD_UNKNOWN) begin
      res.status = lfv_pkg::ST_BAD_RULE;
      return res;
    end
    if (same_sel) k = lfv_pkg::PI4_Q32;
    else k = (unit_sel == lfv_pkg::UNIT_IMPERIAL) ? lfv_pkg::IMP_Q32 : lfv_pkg::MET_Q32;
    as = 64'(area_of(it.ds, k));
    al = 64'(area_of(it.dl, k));
    case (it.cmd)
      lfv_pkg::CMD_SMALIAN: begin
        sum = as + al;
        div = 64'd2 << (2 * lfv_pkg::FRAC_BITS);
      end
      lfv_pkg::CMD_CONE: begin
        sum = as + sqrt_floor(as * al) + al;
        div = 64'd3 << (2 * lfv_pkg::FRAC_BITS);
      end
      default: begin
        sum = as + cbrt_floor(32'(as), 32'(al)) + cbrt_floor(32'(al), 32'(as)) + al;
        div = 64'd4 << (2 * lfv_pkg::FRAC_BITS);
      end
    endcase
    v = (128'(it.len) * 128'(sum) + 128'(div / 2)) / 128'(div);
    if (v > 128'(lfv_pkg::VOL_MAX)) begin
      res.volume = lfv_pkg::VOL_MAX;
      res.status = lfv_pkg::ST_SATURATED;
    end else begin
      res.volume = 40'(v);
      res.status = lfv_pkg::ST_OK;
    end
    return res;
  endfunction

  // driver: presents pending logs, predicts on each transfer
  always @(posedge clk) begin
    log_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.cmd = in_ch.cmd;
        it.ds  = in_ch.small_diameter;
        it.dl  = in_ch.large_diameter;
        it.len = in_ch.log_length;
        volumes_expected.push_back(log_volume(it));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (logs_pending.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
          it = logs_pending.pop_front();
          in_ch.cmd            <= it.cmd;
          in_ch.small_diameter <= it.ds;
          in_ch.large_diameter <= it.dl;
          in_ch.log_length     <= it.len;
          in_ch.valid          <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compares each transfer with the oldest prediction
  always @(posedge clk) begin
    vol_res_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (volumes_expected.size() == 0) begin
          $display("%0t: unexpected result volume=%0d status=%0d", $time,
                   out_ch.volume, out_ch.status);
          errors++;
        end else begin
          exp_r = volumes_expected.pop_front();
          if (out_ch.volume !== exp_r.volume) begin
            $display("%0t: volume expected %0d actual %0d", $time, exp_r.volume,
                     out_ch.volume);
            errors++;
          end
          if (out_ch.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_ch.status);
            errors++;
          end
        end
      end
      out_ch.ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] units, logic same);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lfv_pkg::REG_UNIT_SYSTEM;
    cfg_data  <= units;
    @(posedge clk);
    cfg_index <= lfv_pkg::REG_SAME_UNITS;
    cfg_data  <= {1'b0, same};
    @(posedge clk);
    cfg_we <= 1'b0;
    unit_sel = units;
    same_sel = same;
  endtask

  task automatic wait_idle();
    while (logs_pending.size() > 0 || in_ch.valid || volumes_expected.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_log(logic [1:0] cmd, logic [15:0] ds, logic [15:0] dl, logic [15:0] len);
    log_item_t it;
    it.cmd = cmd;
    it.ds  = ds;
    it.dl  = dl;
    it.len = len;
    logs_pending.push_back(it);
  endtask

  function automatic logic [15:0] rand_size();
    case ($urandom_range(3))
      0: return 16'($urandom_range(255));
      1: return 16'($urandom_range(8191));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] units_list[6];
    logic       same_list[6];
    units_list = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
    same_list  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    errors    = 0;
    stall_cnt = 0;
    quiet     = 1'b0;
    unit_sel  = '0;
    same_sel  = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = '0;
    in_ch.small_diameter = '0;
    in_ch.large_diameter = '0;
    in_ch.log_length     = '0;
    out_ch.ready         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values first: imperial, no same units
    for (int c = 0; c < 4; c++) begin
      add_log(2'(c), 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_log(2'(c), 16'h0000, 16'h0000, 16'h0000);
    end
    add_log(lfv_pkg::CMD_CONE, 16'h0000, 16'hFFFF, 16'hFFFF);
    add_log(lfv_pkg::CMD_NEILOID, 16'hFFFF, 16'h0000, 16'hFFFF);
    add_log(lfv_pkg::CMD_NEILOID, 16'h0001, 16'hFFFF, 16'h0100);
    add_log(lfv_pkg::CMD_SMALIAN, 16'h0100, 16'h0100, 16'h0100);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      write_cfg(units_list[p], same_list[p]);
      quiet = (p == 4);
      for (int c = 0; c < 4; c++) add_log(2'(c), 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int n = 0; n < 60; n++)
        add_log(($urandom_range(9) == 0) ? lfv_pkg::CMD_UNKNOWN : 2'($urandom_range(2)),
                rand_size(), rand_size(), 16'($urandom));
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
